/* design/bankers_resource_allocator_core_assert.svh */
// Assertion macros for the banker's allocator checker.
// Both expect i_clk and i_rst_n in scope; used by the checker module only.
`ifndef BANKERS_RESOURCE_ALLOCATOR_CORE_ASSERT_SVH
`define BANKERS_RESOURCE_ALLOCATOR_CORE_ASSERT_SVH

// same-cycle implication
`define BRA_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BRA_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/bra_pkg.sv */
// Shared types, sizes, codes and helpers for the banker's allocator.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package bra_pkg;

    localparam int CUSTOMERS   = 5;
    localparam int RESOURCES   = 4;
    localparam int AMOUNT_BITS = 8;

    localparam int CUST_BITS = (CUSTOMERS > 1) ? $clog2(CUSTOMERS) : 1;
    localparam int CNT_BITS  = $clog2(CUSTOMERS + 1);
    // fixed lane count of the amount and free ports
    localparam int PORT_LANES = 4;

    typedef logic [AMOUNT_BITS-1:0] t_amt;
    typedef t_amt [RESOURCES-1:0]   t_amt_vec;
    typedef t_amt [PORT_LANES-1:0]  t_amt_lanes;

    localparam t_amt AMOUNT_MAX = '1;

    // command codes
    localparam logic [2:0] CMD_CLEAR   = 3'd0;
    localparam logic [2:0] CMD_LOAD    = 3'd1;
    localparam logic [2:0] CMD_REQUEST = 3'd2;
    localparam logic [2:0] CMD_RELEASE = 3'd3;
    localparam logic [2:0] CMD_RUN     = 3'd4;
    localparam logic [2:0] CMD_REPORT  = 3'd5;

    // result status codes
    localparam logic [2:0] ST_DONE       = 3'd0;
    localparam logic [2:0] ST_OVER_NEED  = 3'd1;
    localparam logic [2:0] ST_NO_FREE    = 3'd2;
    localparam logic [2:0] ST_OVER_ALLOC = 3'd3;
    localparam logic [2:0] ST_UNSAFE     = 3'd4;

    // configuration register indexes (0..3 are the initial free amounts) and the customer count reset value
    localparam logic [2:0] CFG_FREE_0     = 3'd0;
    localparam logic [2:0] CFG_CUST_COUNT = 3'd4;
    localparam logic [2:0] CUST_COUNT_RST = 3'd5;

    // row unit operations
    localparam logic [1:0] ROP_REQUEST = 2'd0;
    localparam logic [1:0] ROP_RELEASE = 2'd1;
    localparam logic [1:0] ROP_RUN     = 2'd2;

    typedef struct packed {
        logic [1:0] op;
        t_amt_vec   max_row;
        t_amt_vec   alloc_row;
        t_amt_vec   opd;
        t_amt_vec   pool;
    } t_row_req;

    typedef struct packed {
        logic     over_need;
        logic     over_pool;
        logic     over_alloc;
        logic     need_fits;
        t_amt_vec row_res;
        t_amt_vec pool_res;
    } t_row_rsp;

    typedef struct packed {
        logic max_we;
        logic alloc_we;
    } t_rf_ctl;

    function automatic t_amt sat_add(input t_amt a, input t_amt b);
        logic [AMOUNT_BITS:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[AMOUNT_BITS] ? AMOUNT_MAX : s[AMOUNT_BITS-1:0];
    endfunction

endpackage

/* design/bra_row_unit.sv */
// Shared row unit: need, compares, saturating add and plain subtract over one row.
// Depends on bra_pkg.
`timescale 1ns / 1ps

module bra_row_unit
    import bra_pkg::*;
(
    input  t_row_req i_req,
    output t_row_rsp o_rsp
);

    t_amt_vec need;
    t_amt_vec addend;

    // one lane per resource type; the flags combine all lanes
    always_comb begin
        o_rsp = '0;
        o_rsp.need_fits = 1'b1;
        for (int r = 0; r < RESOURCES; r++) begin
            need[r] = (i_req.max_row[r] > i_req.alloc_row[r]) ?
                      (i_req.max_row[r] - i_req.alloc_row[r]) : '0;
            addend[r] = (i_req.op == ROP_RUN) ? i_req.alloc_row[r] : i_req.opd[r];

            if (i_req.opd[r] > need[r])           o_rsp.over_need  = 1'b1;
            if (i_req.opd[r] > i_req.pool[r])     o_rsp.over_pool  = 1'b1;
            if (i_req.opd[r] > i_req.alloc_row[r]) o_rsp.over_alloc = 1'b1;
            if (need[r] > i_req.pool[r])          o_rsp.need_fits  = 1'b0;

            o_rsp.row_res[r] = (i_req.op == ROP_RELEASE) ?
                               (i_req.alloc_row[r] - i_req.opd[r]) :
                               sat_add(i_req.alloc_row[r], i_req.opd[r]);
            o_rsp.pool_res[r] = (i_req.op == ROP_REQUEST) ?
                                (i_req.pool[r] - i_req.opd[r]) :
                                sat_add(i_req.pool[r], addend[r]);
        end
    end

endmodule

/* design/bra_row_file.sv */
// Maximum and allocation rows, one row read and written per cycle.
// Depends on bra_pkg; rows outside the customer range read as zero.
`timescale 1ns / 1ps

module bra_row_file
    import bra_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [CUST_BITS-1:0] i_addr,
    input  t_rf_ctl              i_ctl,
    input  t_amt_vec             i_max_row,
    input  t_amt_vec             i_alloc_row,
    output t_amt_vec             o_max_row,
    output t_amt_vec             o_alloc_row
);

    t_amt_vec r_max   [CUSTOMERS];
    t_amt_vec r_alloc [CUSTOMERS];
    logic     addr_ok;

    assign addr_ok = int'(i_addr) < CUSTOMERS;

    // row read
    always_comb begin
        o_max_row   = '0;
        o_alloc_row = '0;
        if (addr_ok) begin
            o_max_row   = r_max[i_addr];
            o_alloc_row = r_alloc[i_addr];
        end
    end

    // row write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < CUSTOMERS; c++) begin
                r_max[c]   <= '0;
                r_alloc[c] <= '0;
            end
        end else if (addr_ok) begin
            if (i_ctl.max_we)   r_max[i_addr]   <= i_max_row;
            if (i_ctl.alloc_we) r_alloc[i_addr] <= i_alloc_row;
        end
    end

endmodule

/* design/bankers_resource_allocator_core.sv */
// Banker's allocator top: command sequencer, free pool, output register.
// Run: the safety search checks one row a cycle in the shared row unit, then, if safe, clears
// allocation rows one a cycle. One item at a time: the next command is taken once the last
// result beat is loaded; results leave at one beat per cycle while i_out_ready is high.
// Sync active-low reset, no clearing pass.
`timescale 1ns / 1ps

module bankers_resource_allocator_core
    import bra_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    // configuration
    input  logic       i_cfg_we,
    input  logic [2:0] i_cfg_idx,
    input  logic [7:0] i_cfg_data,
    // command channel
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [2:0] i_command,
    input  logic [2:0] i_customer_id,
    input  t_amt       i_amount_0,
    input  t_amt       i_amount_1,
    input  t_amt       i_amount_2,
    input  t_amt       i_amount_3,
    // result channel
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [2:0] o_status,
    output logic [2:0] o_order_customer,
    output logic       o_last,
    output t_amt       o_free_0,
    output t_amt       o_free_1,
    output t_amt       o_free_2,
    output t_amt       o_free_3
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CLEAR = 3'd1;
    localparam logic [2:0] S_EXEC  = 3'd2;
    localparam logic [2:0] S_SCAN  = 3'd3;
    localparam logic [2:0] S_ZERO  = 3'd4;
    localparam logic [2:0] S_EMIT  = 3'd5;

    // control and model state
    logic [2:0]           r_state, n_state;
    t_amt_vec             r_free, n_free;
    logic [CUSTOMERS-1:0] r_fin, n_fin;
    logic [CNT_BITS-1:0]  r_done, n_done;
    logic                 r_prog, n_prog;
    logic [CNT_BITS-1:0]  r_n, n_n;
    logic [CNT_BITS-1:0]  r_emit_k, n_emit_k;
    logic [CNT_BITS-1:0]  r_emit_n, n_emit_n;
    logic [2:0]           r_emit_status, n_emit_status;
    logic                 r_emit_order, n_emit_order;
    logic                 r_out_valid, n_out_valid;
    t_amt_lanes           r_init_free;
    logic [2:0]           r_cust_count;

    // payload
    logic [2:0]           r_cmd, n_cmd;
    logic [CUST_BITS-1:0] r_cust, n_cust;
    logic                 r_id_ok, n_id_ok;
    t_amt_vec             r_amt, n_amt;
    t_amt_vec             r_work, n_work;
    logic [CUST_BITS-1:0] r_order [CUSTOMERS];
    logic [CUST_BITS-1:0] n_order [CUSTOMERS];
    logic [2:0]           r_out_status, n_out_status;
    logic [2:0]           r_out_order, n_out_order;
    logic                 r_out_last, n_out_last;
    t_amt_vec             r_out_free, n_out_free;

    // datapath links
    t_row_req   row_req;
    t_row_rsp   row_rsp;
    t_rf_ctl    rf_ctl;
    t_amt_vec   rf_alloc_wdata;
    t_amt_vec   rf_max_row;
    t_amt_vec   rf_alloc_row;
    t_amt_lanes in_lanes;
    t_amt_lanes free_lanes;
    logic       in_fire;
    logic       out_take;
    logic       fits;
    logic       end_pass;
    logic       emit_last;
    logic [CNT_BITS-1:0] done_nx;
    logic       prog_nx;

    assign in_lanes = {i_amount_3, i_amount_2, i_amount_1, i_amount_0};
    assign o_in_ready = (r_state == S_IDLE);
    assign in_fire  = i_in_valid && o_in_ready;
    assign out_take = r_out_valid && i_out_ready;

    bra_row_file u_rows (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_addr      (r_cust),
        .i_ctl       (rf_ctl),
        .i_max_row   (r_amt),
        .i_alloc_row (rf_alloc_wdata),
        .o_max_row   (rf_max_row),
        .o_alloc_row (rf_alloc_row)
    );

    // shared row unit: search compares against the working pool, else the free pool
    always_comb begin
        row_req.op        = (r_state == S_SCAN)      ? ROP_RUN :
                            (r_cmd == CMD_RELEASE)   ? ROP_RELEASE : ROP_REQUEST;
        row_req.max_row   = rf_max_row;
        row_req.alloc_row = rf_alloc_row;
        row_req.opd       = r_amt;
        row_req.pool      = (r_state == S_SCAN) ? r_work : r_free;
    end

    bra_row_unit u_unit (
        .i_req (row_req),
        .o_rsp (row_rsp)
    );

    // search step bookkeeping
    assign fits      = !r_fin[r_cust] && row_rsp.need_fits;
    assign done_nx   = r_done + CNT_BITS'(fits);
    assign prog_nx   = r_prog || fits;
    assign end_pass  = (CNT_BITS'(r_cust) == CNT_BITS'(r_n - 1'b1));
    assign emit_last = (r_emit_k == CNT_BITS'(r_emit_n - 1'b1));

    // sequencer
    always_comb begin
        n_state       = r_state;
        n_free        = r_free;
        n_fin         = r_fin;
        n_done        = r_done;
        n_prog        = r_prog;
        n_n           = r_n;
        n_emit_k      = r_emit_k;
        n_emit_n      = r_emit_n;
        n_emit_status = r_emit_status;
        n_emit_order  = r_emit_order;
        n_out_valid   = r_out_valid && !out_take;
        n_cmd         = r_cmd;
        n_cust        = r_cust;
        n_id_ok       = r_id_ok;
        n_amt         = r_amt;
        n_work        = r_work;
        n_order       = r_order;
        n_out_status  = r_out_status;
        n_out_order   = r_out_order;
        n_out_last    = r_out_last;
        n_out_free    = r_out_free;
        rf_ctl         = '0;
        rf_alloc_wdata = row_rsp.row_res;

        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_cmd   = i_command;
                    n_cust  = CUST_BITS'(i_customer_id);
                    n_id_ok = int'(i_customer_id) < CUSTOMERS;
                    for (int r = 0; r < RESOURCES; r++) n_amt[r] = in_lanes[r];
                    n_emit_k      = '0;
                    n_emit_n      = CNT_BITS'(1);
                    n_emit_status = ST_DONE;
                    n_emit_order  = 1'b0;
                    unique case (i_command)
                        CMD_CLEAR: begin
                            for (int r = 0; r < RESOURCES; r++) n_free[r] = r_init_free[r];
                            n_cust  = '0;
                            n_state = S_CLEAR;
                        end
                        CMD_LOAD, CMD_REQUEST, CMD_RELEASE: begin
                            n_state = S_EXEC;
                        end
                        CMD_RUN: begin
                            n_work = r_free;
                            n_fin  = '0;
                            n_done = '0;
                            n_prog = 1'b0;
                            n_cust = '0;
                            if (r_cust_count == '0)
                                n_n = CNT_BITS'(1);
                            else if (int'(r_cust_count) > CUSTOMERS)
                                n_n = CNT_BITS'(CUSTOMERS);
                            else
                                n_n = CNT_BITS'(r_cust_count);
                            n_state = S_SCAN;
                        end
                        default: begin
                            // report and unused codes
                            n_state = S_EMIT;
                        end
                    endcase
                end
            end

            S_CLEAR: begin
                rf_ctl.alloc_we = 1'b1;
                rf_alloc_wdata  = '0;
                if (int'(r_cust) == CUSTOMERS - 1)
                    n_state = S_EMIT;
                else
                    n_cust = r_cust + 1'b1;
            end

            S_EXEC: begin
                if (r_id_ok) begin
                    priority if (r_cmd == CMD_LOAD) begin
                        rf_ctl.max_we = 1'b1;
                    end else if (r_cmd == CMD_REQUEST) begin
                        priority if (row_rsp.over_need) begin
                            n_emit_status = ST_OVER_NEED;
                        end else if (row_rsp.over_pool) begin
                            n_emit_status = ST_NO_FREE;
                        end else begin
                            rf_ctl.alloc_we = 1'b1;
                            n_free          = row_rsp.pool_res;
                        end
                    end else if (r_cmd == CMD_RELEASE) begin
                        if (row_rsp.over_alloc) begin
                            n_emit_status = ST_OVER_ALLOC;
                        end else begin
                            rf_ctl.alloc_we = 1'b1;
                            n_free          = row_rsp.pool_res;
                        end
                    end
                end
                n_state = S_EMIT;
            end

            S_SCAN: begin
                n_done = done_nx;
                n_prog = prog_nx;
                if (fits) begin
                    n_work = row_rsp.pool_res;
                    n_fin[r_cust] = 1'b1;
                    n_order[r_done[CUST_BITS-1:0]] = r_cust;
                end
                if (end_pass) begin
                    priority if (done_nx == r_n) begin
                        n_free  = fits ? row_rsp.pool_res : r_work;
                        n_cust  = '0;
                        n_state = S_ZERO;
                    end else if (!prog_nx) begin
                        n_emit_status = ST_UNSAFE;
                        n_state       = S_EMIT;
                    end else begin
                        n_cust = '0;
                        n_prog = 1'b0;
                    end
                end else begin
                    n_cust = r_cust + 1'b1;
                end
            end

            S_ZERO: begin
                rf_ctl.alloc_we = 1'b1;
                rf_alloc_wdata  = '0;
                if (end_pass) begin
                    n_emit_n     = r_n;
                    n_emit_order = 1'b1;
                    n_state      = S_EMIT;
                end else begin
                    n_cust = r_cust + 1'b1;
                end
            end

            S_EMIT: begin
                if (!r_out_valid || out_take) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_emit_status;
                    n_out_order  = r_emit_order ?
                                   3'(r_order[r_emit_k[CUST_BITS-1:0]]) : 3'd0;
                    n_out_last   = emit_last;
                    n_out_free   = r_free;
                    n_emit_k     = r_emit_k + 1'b1;
                    if (emit_last) n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control, model state and configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_free        <= '0;
            r_fin         <= '0;
            r_done        <= '0;
            r_prog        <= 1'b0;
            r_n           <= '0;
            r_emit_k      <= '0;
            r_emit_n      <= '0;
            r_emit_status <= ST_DONE;
            r_emit_order  <= 1'b0;
            r_out_valid   <= 1'b0;
            r_init_free   <= '0;
            r_cust_count  <= CUST_COUNT_RST;
        end else begin
            r_state       <= n_state;
            r_free        <= n_free;
            r_fin         <= n_fin;
            r_done        <= n_done;
            r_prog        <= n_prog;
            r_n           <= n_n;
            r_emit_k      <= n_emit_k;
            r_emit_n      <= n_emit_n;
            r_emit_status <= n_emit_status;
            r_emit_order  <= n_emit_order;
            r_out_valid   <= n_out_valid;
            if (i_cfg_we) begin
                if (i_cfg_idx < CFG_CUST_COUNT)
                    r_init_free[i_cfg_idx[1:0] - CFG_FREE_0[1:0]] <=
                        AMOUNT_BITS'(i_cfg_data);
                else if (i_cfg_idx == CFG_CUST_COUNT)
                    r_cust_count <= i_cfg_data[2:0];
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_cmd        <= n_cmd;
        r_cust       <= n_cust;
        r_id_ok      <= n_id_ok;
        r_amt        <= n_amt;
        r_work       <= n_work;
        r_order      <= n_order;
        r_out_status <= n_out_status;
        r_out_order  <= n_out_order;
        r_out_last   <= n_out_last;
        r_out_free   <= n_out_free;
    end

    // pad the free pool onto the four port lanes
    always_comb begin
        free_lanes = '0;
        for (int r = 0; r < RESOURCES; r++) free_lanes[r] = r_out_free[r];
    end

    assign o_out_valid      = r_out_valid;
    assign o_status         = r_out_status;
    assign o_order_customer = r_out_order;
    assign o_last           = r_out_last;
    assign o_free_0         = free_lanes[0];
    assign o_free_1         = free_lanes[1];
    assign o_free_2         = free_lanes[2];
    assign o_free_3         = free_lanes[3];

endmodule

/* design/bra_checker.sv */
// Port-level checker for the banker's allocator, bound to the top level.
// Depends on bra_pkg and bankers_resource_allocator_core_assert.svh.
`timescale 1ns / 1ps
`include "bankers_resource_allocator_core_assert.svh"

module bra_checker
    import bra_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_ready,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic [2:0] o_status,
    input logic [2:0] o_order_customer,
    input logic       o_last,
    input t_amt       o_free_0,
    input t_amt       o_free_1,
    input t_amt       o_free_2,
    input t_amt       o_free_3
);

    logic [6+4*AMOUNT_BITS:0] out_beat;
    logic                     out_stall;
    logic                     out_take;
    logic                     in_take;
    logic                     refusal;
    logic                     lone_beat;

    // handshake and beat terms
    assign out_beat  = {o_status, o_order_customer, o_last,
                        o_free_3, o_free_2, o_free_1, o_free_0};
    assign out_stall = o_out_valid && !i_out_ready;
    assign out_take  = o_out_valid && i_out_ready;
    assign in_take   = i_in_valid && o_in_ready;
    assign refusal   = o_out_valid && (o_status != ST_DONE);
    assign lone_beat = o_last && (o_order_customer == 3'd0);

    // a stalled result beat holds
    `BRA_ASSERT_NXT(a_out_hold, out_stall, o_out_valid && $stable(out_beat), "stalled beat changed")

    // the block is busy the cycle after it takes a command
    `BRA_ASSERT_NXT(a_busy_after_accept, in_take, !o_in_ready, "ready right after a command beat")

    // a refusal or unsafe verdict is a single closing beat with no order entry
    `BRA_ASSERT_IMP(a_refusal_single, refusal, lone_beat, "refusal not a lone final beat")

    // a safe order streams without gaps
    `BRA_ASSERT_NXT(a_order_stream, out_take && !o_last, o_out_valid, "gap inside the safe order")

endmodule

bind bankers_resource_allocator_core bra_checker u_bra_checker (.*);
